FILE: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, masked while reset is high
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds across reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/cpr_pkg.sv
`timescale 1ns / 1ps

package cpr_pkg;

  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 8;

  localparam int CFG_W       = 5;
  localparam int OUTCOME_W   = 2;
  localparam int FRAME_OUT_W = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_FILL  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic hit;
    logic fill;
    logic sweep_clr;
    logic ev_rd;
    logic evict;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic hit;
    logic empty;
    logic ref_set;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/cpr_ctrl.sv
`timescale 1ns / 1ps

module cpr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cpr_pkg::status_t status,
  output cpr_pkg::cmd_t    cmd
);
  import cpr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SWEEP,
    S_EVICT
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:   cmd.start = in_valid && in_ready;
      S_SCAN:   cmd.scan = 1'b1;
      S_DECIDE: begin
        if (status.hit) begin
          cmd.hit = status.out_free;
        end else if (status.empty) begin
          cmd.fill = status.out_free;
        end
      end
      S_SWEEP: begin
        if (status.ref_set) begin
          cmd.sweep_clr = 1'b1;
        end else begin
          cmd.ev_rd = 1'b1;
        end
      end
      S_EVICT:  cmd.evict = status.out_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.start) begin
            state    <= S_SCAN;
            in_ready <= 1'b0;
          end
        end
        S_SCAN: begin
          if (status.scan_done) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (cmd.hit || cmd.fill) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end else if (!status.hit && !status.empty) begin
            state <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (cmd.ev_rd) begin
            state <= S_EVICT;
          end
        end
        S_EVICT: begin
          if (cmd.evict) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

FILE: rtl/cpr_datapath.sv
`timescale 1ns / 1ps

module cpr_datapath #(
  parameter int FRAMES    = cpr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [cpr_pkg::CFG_W-1:0]         frame_count,
  input  logic [PAGE_BITS-1:0]              page,
  input  cpr_pkg::cmd_t                     cmd,
  output cpr_pkg::status_t                  status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cpr_pkg::OUTCOME_W-1:0]     outcome,
  output logic [cpr_pkg::FRAME_OUT_W-1:0]   frame,
  output logic [PAGE_BITS-1:0]              evicted_page,
  output logic [cpr_pkg::FRAME_OUT_W-1:0]   hand_position
);
  import cpr_pkg::*;

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);

  logic [PAGE_BITS-1:0] mem [FRAMES];
  logic [PAGE_BITS-1:0] rd_data;
  logic [PAGE_BITS-1:0] page_q;
  logic [FRAMES-1:0]    frame_valid;
  logic [FRAMES-1:0]    ref_bit;
  logic [IDX_W-1:0]     hand;
  logic [IDX_W-1:0]     hand_inc;
  logic [IDX_W-1:0]     cmp_idx;
  logic [IDX_W-1:0]     hit_idx;
  logic [IDX_W-1:0]     empty_idx;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     scan_idx;
  logic                 cmp_pend;
  logic                 hit_flag;
  logic                 empty_flag;
  logic                 scan_more;
  logic                 rd_en;
  logic                 wr_en;
  logic                 hit_now;
  logic                 empty_now;

  // clamp the register to 1..FRAMES
  always_comb begin
    if (frame_count == '0) begin
      count = CNT_W'(1);
    end else if (int'(frame_count) > FRAMES) begin
      count = CNT_W'(FRAMES);
    end else begin
      count = CNT_W'(frame_count);
    end
  end

  assign hand_inc  = ((CNT_W'(hand) + CNT_W'(1)) == count) ? '0 : hand + IDX_W'(1);
  assign scan_more = scan_idx < count;
  assign rd_en     = (cmd.scan && scan_more) || cmd.ev_rd;
  assign rd_addr   = cmd.ev_rd ? hand : scan_idx[IDX_W-1:0];
  assign wr_en     = cmd.fill || cmd.evict;
  assign wr_addr   = cmd.fill ? empty_idx : hand;

  // first match and first empty frame, in ascending order
  assign hit_now   = cmd.scan && cmp_pend && !hit_flag &&
                     frame_valid[cmp_idx] && (rd_data == page_q);
  assign empty_now = cmd.scan && cmp_pend && !empty_flag && !frame_valid[cmp_idx];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= page_q;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      ref_bit     <= '0;
      hand        <= '0;
      scan_idx    <= '0;
      cmp_pend    <= 1'b0;
      hit_flag    <= 1'b0;
      empty_flag  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.start) begin
        if (CNT_W'(hand) >= count) begin
          hand <= '0;
        end
        scan_idx   <= '0;
        cmp_pend   <= 1'b0;
        hit_flag   <= 1'b0;
        empty_flag <= 1'b0;
      end
      if (cmd.scan) begin
        cmp_pend <= scan_more;
        if (scan_more) begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
        if (hit_now) begin
          hit_flag <= 1'b1;
        end
        if (empty_now) begin
          empty_flag <= 1'b1;
        end
      end
      if (cmd.hit) begin
        ref_bit[hit_idx] <= 1'b1;
      end
      if (cmd.fill) begin
        frame_valid[empty_idx] <= 1'b1;
        ref_bit[empty_idx]     <= 1'b1;
      end
      if (cmd.sweep_clr) begin
        ref_bit[hand] <= 1'b0;
        hand          <= hand_inc;
      end
      if (cmd.evict) begin
        ref_bit[hand] <= 1'b1;
        hand          <= hand_inc;
      end
      if (cmd.hit || cmd.fill || cmd.evict) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      page_q <= page;
    end
    if (cmd.scan && scan_more) begin
      cmp_idx <= scan_idx[IDX_W-1:0];
    end
    if (hit_now) begin
      hit_idx <= cmp_idx;
    end
    if (empty_now) begin
      empty_idx <= cmp_idx;
    end
    if (cmd.hit) begin
      outcome       <= OUTCOME_HIT;
      frame         <= FRAME_OUT_W'(hit_idx);
      evicted_page  <= '0;
      hand_position <= FRAME_OUT_W'(hand);
    end else if (cmd.fill) begin
      outcome       <= OUTCOME_FILL;
      frame         <= FRAME_OUT_W'(empty_idx);
      evicted_page  <= '0;
      hand_position <= FRAME_OUT_W'(hand);
    end else if (cmd.evict) begin
      outcome       <= OUTCOME_EVICT;
      frame         <= FRAME_OUT_W'(hand);
      evicted_page  <= rd_data;
      hand_position <= FRAME_OUT_W'(hand_inc);
    end
  end

  assign status.scan_done = hit_flag || (!scan_more && !cmp_pend);
  assign status.hit       = hit_flag;
  assign status.empty     = empty_flag;
  assign status.ref_set   = ref_bit[hand];
  assign status.out_free  = !out_valid || out_ready;

endmodule

FILE: rtl/clock_page_replacement_top.sv
// a hit ends the scan at the matching frame; a fill follows a scan of all count frames; an
//   eviction follows that scan with a sweep that clears each set reference bit it passes,
//   then reads and replaces the page at the hand; one reference at a time, set by the
//   serial scan of the page store (one frame per cycle through its single read port)
// reset: clears valid and reference bits, the hand and the output beat; frame_count
//   returns to 16; the page store is not cleared, so there is no clearing pass
`timescale 1ns / 1ps

module clock_page_replacement_top #(
  parameter int FRAMES    = cpr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write, no handshake
  input  logic                            cfg_we,
  input  logic [cpr_pkg::CFG_W-1:0]       cfg_wdata,
  // reference input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [PAGE_BITS-1:0]            page,
  // result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cpr_pkg::OUTCOME_W-1:0]   outcome,
  output logic [cpr_pkg::FRAME_OUT_W-1:0] frame,
  output logic [PAGE_BITS-1:0]            evicted_page,
  output logic [cpr_pkg::FRAME_OUT_W-1:0] hand_position
);
  import cpr_pkg::*;

  // frames in use; clamped to 1..FRAMES inside the datapath
  logic [CFG_W-1:0] frame_count;

  cmd_t    cmd;
  status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= CFG_RESET;
    end else if (cfg_we) begin
      frame_count <= cfg_wdata;
    end
  end

  // sequencer: scan for hit and first empty frame, then report the hit, fill, or sweep the hand and evict
  cpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // page store, valid and reference bits, hand, and the output beat register
  // (the output register lets a finished beat wait while the next page is taken)
  cpr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .frame_count   (frame_count),
    .page          (page),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .outcome       (outcome),
    .frame         (frame),
    .evicted_page  (evicted_page),
    .hand_position (hand_position)
  );

endmodule

FILE: rtl/cpr_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpr_checker #(
  parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [cpr_pkg::OUTCOME_W-1:0]   outcome,
  input logic [cpr_pkg::FRAME_OUT_W-1:0] frame,
  input logic [PAGE_BITS-1:0]            evicted_page,
  input logic [cpr_pkg::FRAME_OUT_W-1:0] hand_position
);
  import cpr_pkg::*;

  // a stalled result beat holds
  `ASSERT_SYNC(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(frame) && $stable(evicted_page) && $stable(hand_position), "result beat changed while stalled")

  // one reference in flight
  `ASSERT_SYNC(a_one_in_flight, clk, rst, in_valid && in_ready |=> !in_ready, "input taken while a reference is in progress")

  // only an eviction reports a removed page
  `ASSERT_SYNC(a_evict_page_zero, clk, rst, out_valid && outcome != OUTCOME_EVICT |-> evicted_page == '0, "evicted page nonzero without eviction")

  // reset leaves the block ready with no pending beat
  `ASSERT_ALWAYS(a_reset_state, clk, rst |=> in_ready && !out_valid, "bad state after reset")

endmodule

bind clock_page_replacement_top cpr_checker #(.PAGE_BITS(PAGE_BITS)) u_cpr_checker (.*);
